### rtl/btt_pkg.sv
// Package for the blob track table: widths, defaults, register indexes, record types.
// No dependencies.
`default_nettype none
package btt_pkg;
  localparam int MaxTracks = 32;
  localparam int MaxNew = 16;
  localparam int CfgW = 12;
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegTol = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMinAge = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRatio = 2'd2;
  localparam logic [CfgIdxW-1:0] RegHoldoff = 2'd3;
  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] s;
  } pos_t;
  typedef struct packed {
    logic [15:0] cnt;
    logic [15:0] age;
  } ha_t;
endpackage
`default_nettype wire

### rtl/btt_if.sv
// Valid/ready channel interfaces for blobs and frame results.
// Depends on nothing.
`default_nettype none
interface btt_in_if;
  logic valid;
  logic ready;
  logic point_present;
  logic [11:0] point_x;
  logic [11:0] point_y;
  logic [11:0] point_size;
  logic frame_end;
  modport source (output valid, point_present, point_x, point_y, point_size, frame_end,
                  input ready);
  modport sink (input valid, point_present, point_x, point_y, point_size, frame_end,
                output ready);
endinterface

interface btt_out_if;
  logic valid;
  logic ready;
  logic hit_valid;
  logic [11:0] hit_x;
  logic [11:0] hit_y;
  logic [5:0] track_total;
  logic [4:0] new_total;
  logic overflow;
  modport source (output valid, hit_valid, hit_x, hit_y, track_total, new_total, overflow,
                  input ready);
  modport sink (input valid, hit_valid, hit_x, hit_y, track_total, new_total, overflow,
                output ready);
endinterface
`default_nettype wire

### rtl/btt_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module btt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/btt_div.sv
// Restoring divider: 16-bit dividend by DivW-bit divisor, one bit per cycle.
// No dependencies.
`default_nettype none
module btt_div #(
  parameter int DivW = 5
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [15:0]     num,
  input  wire logic [DivW-1:0] den,
  output logic                 busy,
  output logic [15:0]          quo
);
  logic [4:0]      step;
  logic [DivW:0]   rem;
  logic [DivW-1:0] d;
  logic [DivW:0]   trial;

  assign trial = {rem[DivW-1:0], quo[15]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 5'd0;
      rem  <= '0;
      quo  <= num;
      d    <= den;
    end else if (busy) begin
      // shift one dividend bit in, subtract if it fits
      if (trial >= {1'b0, d}) begin
        rem <= trial - {1'b0, d};
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[14:0], 1'b0};
      end
      step <= step + 5'd1;
      if (step == 5'd15) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### rtl/blob_track_table_with_hit_detect_core.sv
// Blob track table with hit detection. Each blob walks the track table one entry per
// cycle through a memory with registered read data.
// At a frame end two dividers form the centroid, then one sweep ages and compacts the
// table in place (read index ahead of write index) and a second appends the buffered
// new blobs. The result waits in an output register; one item is handled at a time.
// Depends on btt_pkg, btt_if, btt_ram, btt_div.
`default_nettype none
module blob_track_table_with_hit_detect_core #(
  parameter int MaxTracks = btt_pkg::MaxTracks,
  parameter int MaxNew = btt_pkg::MaxNew
) (
  input  wire logic clk,
  input  wire logic rst,
  btt_in_if.sink    in_ch,
  btt_out_if.source out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [btt_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [btt_pkg::CfgW-1:0]    cfg_data
);
  localparam int TW = $clog2(MaxTracks);
  localparam int TCW = $clog2(MaxTracks + 1);
  localparam int NW = (MaxNew > 1) ? $clog2(MaxNew) : 1;
  localparam int NCW = $clog2(MaxNew + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_AGE  = 3'd3;
  localparam logic [2:0] S_APP  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;
  logic [11:0] tol;
  logic [7:0] min_age, holdoff_lim, timer;
  logic [6:0] ratio;
  logic [TCW-1:0] used, ridx, widx;
  logic [NCW-1:0] pused, pidx;
  logic [15:0] sum_x, sum_y;
  logic armed, ovf, rd_pending, fe_hold;
  btt_pkg::pos_t blob;
  logic [11:0] hx, hy;
  logic blob_new;   // blob still unmatched during scan
  logic blob_on;    // item carried a blob

  // memories
  logic tp_we, th_we, pp_we;
  logic [TW-1:0] t_waddr, t_raddr;
  btt_pkg::pos_t tp_wdata, tp_rdata, pp_rdata;
  btt_pkg::ha_t th_wdata, th_rdata;
  logic [NW-1:0] pp_raddr;

  btt_ram #(.Width(36), .Depth(MaxTracks)) u_tpos (.clk, .we(tp_we), .waddr(t_waddr),
    .wdata(tp_wdata), .raddr(t_raddr), .rdata(tp_rdata));
  btt_ram #(.Width(32), .Depth(MaxTracks)) u_tha (.clk, .we(th_we), .waddr(t_waddr),
    .wdata(th_wdata), .raddr(t_raddr), .rdata(th_rdata));
  btt_ram #(.Width(36), .Depth(MaxNew)) u_ppos (.clk, .we(pp_we),
    .waddr(pused[NW-1:0]), .wdata(blob), .raddr(pp_raddr), .rdata(pp_rdata));

  // dividers
  logic div_start, dbx, dby;
  logic [15:0] qx, qy;
  btt_div #(.DivW(NCW)) u_divx (.clk, .rst, .start(div_start), .num(sum_x),
    .den(pused), .busy(dbx), .quo(qx));
  btt_div #(.DivW(NCW)) u_divy (.clk, .rst, .start(div_start), .num(sum_y),
    .den(pused), .busy(dby), .quo(qy));

  // match of current read entry
  logic [11:0] dx, dy, ds;
  logic hit;
  always_comb begin
    dx = (blob.x > tp_rdata.x) ? blob.x - tp_rdata.x : tp_rdata.x - blob.x;
    dy = (blob.y > tp_rdata.y) ? blob.y - tp_rdata.y : tp_rdata.y - blob.y;
    ds = (blob.s > tp_rdata.s) ? blob.s - tp_rdata.s : tp_rdata.s - blob.s;
    hit = (dx < tol) && (dy < tol) && (ds < tol);
  end

  // aging and prune decision
  logic [15:0] age_inc;
  logic [22:0] cnt100;
  logic [22:0] rat_age;
  logic drop;
  always_comb begin
    age_inc = (th_rdata.age != 16'hFFFF) ? th_rdata.age + 16'd1 : th_rdata.age;
    cnt100 = 23'(th_rdata.cnt) * 23'd100;
    rat_age = 23'(ratio) * 23'(age_inc);
    drop = (age_inc > 16'(min_age)) && (cnt100 < rat_age);
  end

  // timer advance for frame end
  logic [7:0] t1, t2;
  always_comb begin
    t1 = armed ? timer + 8'd1 : timer;
    t2 = t1;
    if (t1 != 8'd0) begin
      t2 = t1 + 8'd1;
      if (t2 >= holdoff_lim) t2 = 8'd0;
    end
  end

  logic at_end;
  assign at_end = (state == S_SCAN) && !rd_pending && (ridx >= used);

  // scan of the current item is finished this cycle
  logic scan_done;
  assign scan_done = (state == S_SCAN) && !rd_pending && (!blob_on || ridx >= used);

  always_comb begin
    tp_we = 1'b0;
    th_we = 1'b0;
    pp_we = 1'b0;
    t_waddr = widx[TW-1:0];
    t_raddr = ridx[TW-1:0];
    tp_wdata = tp_rdata;
    th_wdata = th_rdata;
    pp_raddr = pidx[NW-1:0];
    unique case (state)
      S_SCAN: begin
        t_waddr = TW'(ridx - TCW'(1));
        if (rd_pending && hit) begin
          th_we = 1'b1;
          th_wdata.cnt = (th_rdata.cnt != 16'hFFFF) ? th_rdata.cnt + 16'd1 : th_rdata.cnt;
        end
        if (at_end && blob_new && pused < NCW'(MaxNew)) pp_we = 1'b1;
      end
      S_AGE: begin
        if (rd_pending && !drop) begin
          tp_we = 1'b1;
          th_we = 1'b1;
          th_wdata.age = age_inc;
        end
      end
      S_APP: begin
        if (rd_pending && widx < TCW'(MaxTracks)) begin
          tp_we = 1'b1;
          th_we = 1'b1;
          tp_wdata = pp_rdata;
          th_wdata = '0;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= 12'd200;
      min_age <= 8'd3;
      ratio <= 7'd95;
      holdoff_lim <= 8'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        btt_pkg::RegTol:     tol <= cfg_data;
        btt_pkg::RegMinAge:  min_age <= cfg_data[7:0];
        btt_pkg::RegRatio:   ratio <= cfg_data[6:0];
        btt_pkg::RegHoldoff: holdoff_lim <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // start both dividers once the last blob of a frame has been counted
  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= scan_done && fe_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      pused <= '0;
      sum_x <= '0;
      sum_y <= '0;
      armed <= 1'b0;
      ovf <= 1'b0;
      timer <= '0;
      rd_pending <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          // take a transfer
          if (in_ch.valid) begin
            blob <= '{x: in_ch.point_x, y: in_ch.point_y, s: in_ch.point_size};
            blob_on <= in_ch.point_present;
            blob_new <= in_ch.point_present;
            fe_hold <= in_ch.frame_end;
            ridx <= '0;
            rd_pending <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // walk tracks one per cycle, stop at first match
          if (rd_pending && hit) begin
            blob_new <= 1'b0;
            ridx <= used;
            rd_pending <= 1'b0;
          end else if (!blob_on || ridx >= used) begin
            rd_pending <= 1'b0;
            if (!rd_pending) begin
              if (blob_new) begin
                if (timer == 8'd0) armed <= 1'b1;
                if (pused < NCW'(MaxNew)) begin
                  pused <= pused + NCW'(1);
                  sum_x <= sum_x + 16'(blob.x);
                  sum_y <= sum_y + 16'(blob.y);
                end else begin
                  ovf <= 1'b1;
                end
              end
              if (fe_hold) begin
                state <= S_DIV;
              end else begin
                state <= S_IDLE;
              end
            end
          end else begin
            ridx <= ridx + TCW'(1);
            rd_pending <= 1'b1;
          end
        end
        S_DIV: begin
          if (!div_start && !dbx && !dby) begin
            hx <= (armed && pused != '0) ? qx[11:0] : 12'd0;
            hy <= (armed && pused != '0) ? qy[11:0] : 12'd0;
            timer <= t2;
            ridx <= '0;
            widx <= '0;
            rd_pending <= 1'b0;
            state <= S_AGE;
          end
        end
        S_AGE: begin
          // compact surviving tracks toward the front
          if (rd_pending && !drop) widx <= widx + TCW'(1);
          if (ridx < used) begin
            ridx <= ridx + TCW'(1);
            rd_pending <= 1'b1;
          end else begin
            rd_pending <= 1'b0;
            if (!rd_pending) begin
              pidx <= '0;
              state <= S_APP;
            end
          end
        end
        S_APP: begin
          // append buffered new blobs
          if (rd_pending) begin
            if (widx < TCW'(MaxTracks)) widx <= widx + TCW'(1);
            else ovf <= 1'b1;
          end
          if (pidx < pused) begin
            pidx <= pidx + NCW'(1);
            rd_pending <= 1'b1;
          end else begin
            rd_pending <= 1'b0;
            if (!rd_pending) state <= S_OUT;
          end
        end
        S_OUT: begin
          // present result once output register is free
          if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
            out_ch.hit_valid <= armed;
            out_ch.hit_x <= hx;
            out_ch.hit_y <= hy;
            out_ch.track_total <= 6'(widx);
            out_ch.new_total <= 5'(pused);
            out_ch.overflow <= ovf;
            used <= widx;
            pused <= '0;
            sum_x <= '0;
            sum_y <= '0;
            armed <= 1'b0;
            ovf <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_used: assert property (@(posedge clk) disable iff (rst) used <= TCW'(MaxTracks))
    else $error("track count exceeds table size");
  a_pend: assert property (@(posedge clk) disable iff (rst) pused <= NCW'(MaxNew))
    else $error("new-blob count exceeds buffer");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> state == S_SCAN)
    else $error("accepted item not scanned");
  a_comp: assert property (@(posedge clk) disable iff (rst)
    state == S_AGE |-> widx <= ridx)
    else $error("compaction write passed read");
`endif
endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the blob track table: drives blob items and frame ends,
// predicts each frame result and checks it. Depends on btt_pkg, btt_if and the core.
`default_nettype none
typedef struct packed {
  bit        hit_valid;
  bit [11:0] hit_x;
  bit [11:0] hit_y;
  bit [5:0]  track_total;
  bit [4:0]  new_total;
  bit        overflow;
} frame_res_t;

class track_scoreboard;
  // configuration copy
  int unsigned tol, min_age, ratio, holdoff_lim;
  // track table and new-blob buffer
  bit [11:0] tx[btt_pkg::MaxTracks], ty[btt_pkg::MaxTracks], ts[btt_pkg::MaxTracks];
  int unsigned tcnt[btt_pkg::MaxTracks], tage[btt_pkg::MaxTracks];
  int unsigned tused;
  bit [11:0] px[btt_pkg::MaxNew], py[btt_pkg::MaxNew], ps[btt_pkg::MaxNew];
  int unsigned pused, sx, sy, timer;
  bit armed, dropped;
  frame_res_t pending_frames[$];
  int errors, frames_checked, hits_seen, overflows_seen;

  function void clear();
    tol = 200; min_age = 3; ratio = 95; holdoff_lim = 20;
    tused = 0; pused = 0; sx = 0; sy = 0; timer = 0; armed = 0; dropped = 0;
  endfunction

  function void write_reg(bit [1:0] idx, bit [11:0] val);
    case (idx)
      btt_pkg::RegTol:     tol = val;
      btt_pkg::RegMinAge:  min_age = val[7:0];
      btt_pkg::RegRatio:   ratio = val[6:0];
      btt_pkg::RegHoldoff: holdoff_lim = val[7:0];
      default: ;
    endcase
  endfunction

  function int unsigned abs_diff(bit [11:0] a, bit [11:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function void take_blob(bit [11:0] x, bit [11:0] y, bit [11:0] s);
    for (int i = 0; i < tused; i++) begin
      if (abs_diff(x, tx[i]) < tol && abs_diff(y, ty[i]) < tol &&
          abs_diff(s, ts[i]) < tol) begin
        if (tcnt[i] < 65535) tcnt[i]++;
        return;
      end
    end
    if (timer == 0) armed = 1;
    if (pused < btt_pkg::MaxNew) begin
      px[pused] = x; py[pused] = y; ps[pused] = s;
      pused++;
      sx += x; sy += y;
    end else begin
      dropped = 1;
    end
  endfunction

  // Note an accepted input transfer; a frame end queues one expected result.
  function void note_item(bit present, bit [11:0] x, bit [11:0] y, bit [11:0] s, bit fe);
    frame_res_t r;
    int unsigned kept, age;
    if (present) take_blob(x, y, s);
    if (!fe) return;
    r.hit_valid = armed;
    r.hit_x = 0;
    r.hit_y = 0;
    if (armed) begin
      if (pused != 0) begin
        r.hit_x = 12'(sx / pused);
        r.hit_y = 12'(sy / pused);
      end
      timer = (timer + 1) & 8'hff;
    end
    if (timer != 0) begin
      timer = (timer + 1) & 8'hff;
      if (timer >= holdoff_lim) timer = 0;
    end
    // age, prune and compact the old tracks
    kept = 0;
    for (int i = 0; i < tused; i++) begin
      age = tage[i];
      if (age < 65535) age++;
      if (age > min_age && tcnt[i] * 100 < ratio * age) continue;
      tx[kept] = tx[i]; ty[kept] = ty[i]; ts[kept] = ts[i];
      tcnt[kept] = tcnt[i]; tage[kept] = age;
      kept++;
    end
    tused = kept;
    // append the new blobs
    for (int i = 0; i < pused; i++) begin
      if (tused < btt_pkg::MaxTracks) begin
        tx[tused] = px[i]; ty[tused] = py[i]; ts[tused] = ps[i];
        tcnt[tused] = 0; tage[tused] = 0;
        tused++;
      end else begin
        dropped = 1;
      end
    end
    r.track_total = 6'(tused);
    r.new_total = 5'(pused);
    r.overflow = dropped;
    pending_frames = {pending_frames, r};
    pused = 0; sx = 0; sy = 0; armed = 0; dropped = 0;
  endfunction

  function void check_result(frame_res_t got);
    frame_res_t exp;
    if (pending_frames.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected frame result: hit=%0d x=%0d y=%0d",
                                 got.hit_valid, got.hit_x, got.hit_y);
      return;
    end
    exp = pending_frames.pop_front();
    frames_checked++;
    hits_seen += exp.hit_valid;
    overflows_seen += exp.overflow;
    if (got != exp) begin
      errors++;
      if (errors <= 10)
        $display({"frame %0d mismatch: exp hit=%0d x=%0d y=%0d tracks=%0d new=%0d ovf=%0d",
                  " / got hit=%0d x=%0d y=%0d tracks=%0d new=%0d ovf=%0d"},
                 frames_checked, exp.hit_valid, exp.hit_x, exp.hit_y, exp.track_total,
                 exp.new_total, exp.overflow,
                 got.hit_valid, got.hit_x, got.hit_y, got.track_total, got.new_total,
                 got.overflow);
    end
  endfunction
endclass

module testbench;
  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 200;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [btt_pkg::CfgIdxW-1:0] cfg_index = btt_pkg::RegTol;
  logic [btt_pkg::CfgW-1:0] cfg_data = 0;

  btt_in_if in_bus();
  btt_out_if out_bus();

  blob_track_table_with_hit_detect_core uut (
    .clk(clk), .rst(rst), .in_ch(in_bus), .out_ch(out_bus),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  track_scoreboard sb = new();
  bit calm = 0;          // no idling on either side
  logic freeze = 0;      // long receiver hold-off
  bit freeze_go = 0;
  int stall_left = 0;
  int cycles = 0;
  int blobs_sent = 0;
  int jitter = 40;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    in_bus.valid = 0;
    in_bus.point_present = 0;
    in_bus.point_x = 0;
    in_bus.point_y = 0;
    in_bus.point_size = 0;
    in_bus.frame_end = 0;
    out_bus.ready = 0;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: check each result transfer, then stall at random.
  always @(posedge clk) begin
    frame_res_t got;
    if (rst) begin
      out_bus.ready <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.hit_valid = out_bus.hit_valid;
        got.hit_x = out_bus.hit_x;
        got.hit_y = out_bus.hit_y;
        got.track_total = out_bus.track_total;
        got.new_total = out_bus.new_total;
        got.overflow = out_bus.overflow;
        sb.check_result(got);
        stall_left = calm ? 0 : $urandom_range(0, 18);
      end
      if (freeze) begin
        out_bus.ready <= 0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 0;
      end else begin
        out_bus.ready <= 1;
      end
    end
  end

  // Hold the receiver off for a long stretch once.
  initial begin
    wait (freeze_go);
    @(posedge clk);
    freeze <= 1;
    repeat (600) @(posedge clk);
    freeze <= 0;
  end

  task automatic write_reg(logic [btt_pkg::CfgIdxW-1:0] idx, logic [btt_pkg::CfgW-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Wait until every frame result is back and the block has settled.
  task automatic drain();
    in_bus.valid <= 0;
    @(posedge clk);
    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_item(bit present, bit [11:0] x, bit [11:0] y, bit [11:0] s, bit fe);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_bus.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1;
    in_bus.point_present <= present;
    in_bus.point_x <= x;
    in_bus.point_y <= y;
    in_bus.point_size <= s;
    in_bus.frame_end <= fe;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_item(present, x, y, s, fe);
    blobs_sent += present;
  endtask

  function automatic bit [11:0] nudge(bit [11:0] v);
    int r;
    r = int'(v) + $urandom_range(0, 2 * jitter) - jitter;
    if (r < 0) r = 0;
    if (r > 4095) r = 4095;
    return 12'(r);
  endfunction

  // One frame: mostly blobs near known tracks, some fresh ones, a few idle items.
  task automatic send_frame(int nblobs, output int sent);
    bit [11:0] x, y, s;
    bit present, fe;
    int k;
    sent = 0;
    for (int i = 0; i <= nblobs; i++) begin
      fe = (i == nblobs);
      present = fe ? 1'($urandom_range(0, 1)) : 1'b1;
      if (!fe && $urandom_range(0, 15) == 0)
        send_item(0, 12'($urandom), 12'($urandom), 12'($urandom), 0);
      if (sb.tused > 0 && $urandom_range(0, 2) != 0) begin
        k = $urandom_range(0, sb.tused - 1);
        x = nudge(sb.tx[k]); y = nudge(sb.ty[k]); s = nudge(sb.ts[k]);
      end else begin
        x = 12'($urandom); y = 12'($urandom); s = 12'($urandom);
      end
      send_item(present, x, y, s, fe);
      sent++;
    end
  endtask

  task automatic random_frames(int items, int max_blobs);
    int done, n;
    done = 0;
    while (done < items) begin
      calm = ($urandom_range(0, 7) == 0);
      send_frame($urandom_range(0, max_blobs), n);
      done += n;
    end
    calm = 0;
  endtask

  initial begin
    sb.clear();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes, blob with frame end, bare frame end, idle item.
    send_item(1, 12'd0, 12'd0, 12'd0, 0);
    send_item(1, 12'hfff, 12'hfff, 12'hfff, 0);
    send_item(0, 12'hfff, 12'h000, 12'hfff, 0);
    send_item(1, 12'd0, 12'd0, 12'd0, 1);
    send_item(0, 12'd0, 12'd0, 12'd0, 1);
    send_item(1, 12'd100, 12'd4000, 12'd50, 1);
    // Overflow the new-blob buffer.
    for (int i = 0; i < btt_pkg::MaxNew + 2; i++)
      send_item(1, 12'(4095 - i * 200), 12'(i * 200), 12'(i * 150),
                i == btt_pkg::MaxNew + 1);
    drain();
    random_frames(250, 6);
    drain();

    // Zero tolerance, prune eagerly, shortest hold-off.
    write_reg(btt_pkg::RegTol, 0);
    write_reg(btt_pkg::RegMinAge, 0);
    write_reg(btt_pkg::RegRatio, 100);
    write_reg(btt_pkg::RegHoldoff, 2);
    random_frames(150, 5);
    drain();

    // Never prune, longest hold-off: fill the track table.
    write_reg(btt_pkg::RegMinAge, 255);
    write_reg(btt_pkg::RegRatio, 0);
    write_reg(btt_pkg::RegHoldoff, 255);
    random_frames(150, 12);
    drain();

    // Widest tolerance, mid pruning.
    write_reg(btt_pkg::RegTol, 12'hfff);
    write_reg(btt_pkg::RegMinAge, 1);
    write_reg(btt_pkg::RegRatio, 50);
    write_reg(btt_pkg::RegHoldoff, 3);
    random_frames(150, 6);
    drain();

    // Defaults but a wider tolerance, with a long receiver hold-off while items keep coming.
    write_reg(btt_pkg::RegTol, 300);
    write_reg(btt_pkg::RegMinAge, 3);
    write_reg(btt_pkg::RegRatio, 95);
    write_reg(btt_pkg::RegHoldoff, 20);
    freeze_go = 1;
    jitter = 120;
    random_frames(300, 6);
    drain();

    $display("%0d blobs in %0d frames checked, %0d hits, %0d overflow frames",
             blobs_sent, sb.frames_checked, sb.hits_seen, sb.overflows_seen);
    $display("five register settings, %0d mismatches", sb.errors);
    if (sb.errors == 0 && sb.pending_frames.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
